// ===== src/tgff_pkg.sv =====
// Types and constants for the tile grid flood-fill block.
// No dependencies; used by tile_grid_flood_fill.
package tgff_pkg;

    localparam int MODE_W    = 2;
    localparam int POS_W     = 5;
    localparam int TILE_W    = 8;
    localparam int COORD_W   = 6;   // stack coordinate, two's complement, -1 is off grid
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PAINT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_POP,
        ST_FETCH,
        ST_CHECK,
        ST_PUSH,
        ST_DONE
    } state_t;

    // neighbour push order: col+1, col-1, row+1, row-1
    typedef enum logic [1:0] {
        NBR_EAST,
        NBR_WEST,
        NBR_SOUTH,
        NBR_NORTH
    } nbr_t;

endpackage

// ===== src/tile_grid_flood_fill.sv =====
// Tile grid with read, paint and stack-based 4-connected flood fill.
// Depends on tgff_pkg (state and neighbour types, mode codes, widths).
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one command word:
//   mode, col, row, wr_tile. Master stream (m_tvalid/m_tready/m_tdata)
//   returns exactly one word per command: prev_tile and changed.
//   One command is worked at a time; s_tready is high only while idle.
//   From acceptance to m_tvalid: a read or paint passes READ, then DONE;
//   a command off the grid goes straight to DONE. A fill passes READ and
//   then, per popped stack entry, POP and FETCH (an off-grid entry ends
//   there), CHECK (no match, or painted with no room to push, ends there)
//   and PUSH for the four neighbours; POP on an empty stack leads to DONE.
//   A fill of the default 20x18 grid pops at most 1441 entries. A new
//   command is taken only once the last one has left DONE.
//   Reset: the grid is swept to zero one cell a cycle, all GRID_WIDTH *
//   GRID_HEIGHT cells (360 by default); s_tready stays low meanwhile.
//   Stall: the result sits in an output register; the next command is
//   taken while it waits. A finished command holds in DONE until the
//   output register is free.
module tile_grid_flood_fill #(
    parameter int GRID_WIDTH  = 20,
    parameter int GRID_HEIGHT = 18,
    parameter int STACK_SIZE  = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] mode, [6:2] col, [11:7] row, [19:12] wr_tile, [23:20] zero
    input  logic [tgff_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] prev_tile, [8] changed, [15:9] zero
    output logic [tgff_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CW         = tgff_pkg::COORD_W;
    localparam int TW         = tgff_pkg::TILE_W;
    localparam int GRID_CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW         = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int SAW        = $clog2(STACK_SIZE);
    localparam int DW         = $clog2(STACK_SIZE + 1);

    // row-major cell address
    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                 input logic [CW-1:0] r);
        cell_addr = AW'(r * GRID_WIDTH + c);
    endfunction

    function automatic logic on_grid(input logic [CW-1:0] c, input logic [CW-1:0] r);
        on_grid = (c < CW'(GRID_WIDTH)) && (r < CW'(GRID_HEIGHT));
    endfunction

    // input word fields
    logic [tgff_pkg::MODE_W-1:0] in_mode;
    logic [CW-1:0]               in_col;
    logic [CW-1:0]               in_row;
    logic [TW-1:0]               in_tile;

    assign in_mode = s_tdata[1:0];
    assign in_col  = {1'b0, s_tdata[6:2]};
    assign in_row  = {1'b0, s_tdata[11:7]};
    assign in_tile = s_tdata[19:12];

    tgff_pkg::state_t state_reg, state_next;
    tgff_pkg::nbr_t   nbr_reg, nbr_next;

    logic [tgff_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [CW-1:0]               col_reg, col_next;
    logic [CW-1:0]               row_reg, row_next;
    logic [TW-1:0]               tile_reg, tile_next;
    logic [TW-1:0]               old_reg, old_next;
    logic                        chg_reg, chg_next;
    logic [DW-1:0]               depth_reg, depth_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic                        out_valid_reg, out_valid_next;
    logic [TW-1:0]               out_old_reg, out_old_next;
    logic                        out_chg_reg, out_chg_next;

    // grid memory port
    logic [TW-1:0] grid_mem [GRID_CELLS];
    logic          grid_we, grid_re;
    logic [AW-1:0] grid_waddr, grid_raddr;
    logic [TW-1:0] grid_wdata;
    logic [TW-1:0] grid_rd_reg;

    // stack memory port
    logic [2*CW-1:0] stk_mem [STACK_SIZE];
    logic            stk_we, stk_re;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [2*CW-1:0] stk_wdata;
    logic [2*CW-1:0] stk_rd_reg;

    logic            accept;
    logic            out_free;
    logic            room4;
    logic [DW-1:0]   depth_m1;
    logic [CW-1:0]   pop_col, pop_row;
    logic [CW-1:0]   nbr_col, nbr_row;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign room4    = ({1'b0, depth_reg} + (DW+1)'(4)) < (DW+1)'(STACK_SIZE);
    assign depth_m1 = depth_reg - DW'(1);
    assign pop_col  = stk_rd_reg[CW-1:0];
    assign pop_row  = stk_rd_reg[2*CW-1:CW];

    always_comb
    begin
        nbr_col = col_reg;
        nbr_row = row_reg;
        case (nbr_reg)
            tgff_pkg::NBR_EAST:  nbr_col = col_reg + CW'(1);
            tgff_pkg::NBR_WEST:  nbr_col = col_reg - CW'(1);
            tgff_pkg::NBR_SOUTH: nbr_row = row_reg + CW'(1);
            tgff_pkg::NBR_NORTH: nbr_row = row_reg - CW'(1);
            default:             nbr_col = col_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tgff_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(GRID_CELLS - 1))
                    state_next = tgff_pkg::ST_IDLE;
            end
            tgff_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = on_grid(in_col, in_row) ? tgff_pkg::ST_READ
                                                         : tgff_pkg::ST_DONE;
            end
            tgff_pkg::ST_READ:
            begin
                if (mode_reg == tgff_pkg::MODE_FILL && grid_rd_reg != tile_reg)
                    state_next = tgff_pkg::ST_POP;
                else
                    state_next = tgff_pkg::ST_DONE;
            end
            tgff_pkg::ST_POP:
                state_next = (depth_reg == '0) ? tgff_pkg::ST_DONE : tgff_pkg::ST_FETCH;
            tgff_pkg::ST_FETCH:
                state_next = on_grid(pop_col, pop_row) ? tgff_pkg::ST_CHECK
                                                       : tgff_pkg::ST_POP;
            tgff_pkg::ST_CHECK:
                state_next = (grid_rd_reg == old_reg && room4) ? tgff_pkg::ST_PUSH
                                                               : tgff_pkg::ST_POP;
            tgff_pkg::ST_PUSH:
            begin
                if (nbr_reg == tgff_pkg::NBR_NORTH)
                    state_next = tgff_pkg::ST_POP;
            end
            tgff_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = tgff_pkg::ST_IDLE;
            end
            default:
                state_next = tgff_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mode_next      = mode_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        tile_next      = tile_reg;
        old_next       = old_reg;
        chg_next       = chg_reg;
        depth_next     = depth_reg;
        clr_next       = clr_reg;
        nbr_next       = nbr_reg;
        out_old_next   = out_old_reg;
        out_chg_next   = out_chg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        grid_we        = 1'b0;
        grid_re        = 1'b0;
        grid_waddr     = cell_addr(col_reg, row_reg);
        grid_raddr     = cell_addr(col_reg, row_reg);
        grid_wdata     = tile_reg;
        stk_we         = 1'b0;
        stk_re         = 1'b0;
        stk_waddr      = depth_reg[SAW-1:0];
        stk_raddr      = depth_m1[SAW-1:0];
        stk_wdata      = {nbr_row, nbr_col};
        case (state_reg)
            tgff_pkg::ST_CLEAR:
            begin
                grid_we    = 1'b1;
                grid_waddr = clr_reg;
                grid_wdata = '0;
                clr_next   = clr_reg + AW'(1);
            end
            tgff_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                mode_next  = in_mode;
                col_next   = in_col;
                row_next   = in_row;
                tile_next  = in_tile;
                old_next   = '0;
                chg_next   = 1'b0;
                grid_re    = accept;
                grid_raddr = cell_addr(in_col, in_row);
            end
            tgff_pkg::ST_READ:
            begin
                old_next = grid_rd_reg;
                if (mode_reg == tgff_pkg::MODE_PAINT)
                begin
                    grid_we  = 1'b1;
                    chg_next = 1'b1;
                end
                else if (mode_reg == tgff_pkg::MODE_FILL && grid_rd_reg != tile_reg)
                begin
                    // seed the stack with the start cell
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = {row_reg, col_reg};
                    depth_next = DW'(1);
                    chg_next   = 1'b1;
                end
            end
            tgff_pkg::ST_POP:
            begin
                if (depth_reg != '0)
                begin
                    stk_re     = 1'b1;
                    depth_next = depth_m1;
                end
            end
            tgff_pkg::ST_FETCH:
            begin
                col_next   = pop_col;
                row_next   = pop_row;
                grid_re    = on_grid(pop_col, pop_row);
                grid_raddr = cell_addr(pop_col, pop_row);
            end
            tgff_pkg::ST_CHECK:
            begin
                nbr_next = tgff_pkg::NBR_EAST;
                if (grid_rd_reg == old_reg)
                    grid_we = 1'b1;
            end
            tgff_pkg::ST_PUSH:
            begin
                stk_we     = 1'b1;
                depth_next = depth_reg + DW'(1);
                case (nbr_reg)
                    tgff_pkg::NBR_EAST:  nbr_next = tgff_pkg::NBR_WEST;
                    tgff_pkg::NBR_WEST:  nbr_next = tgff_pkg::NBR_SOUTH;
                    tgff_pkg::NBR_SOUTH: nbr_next = tgff_pkg::NBR_NORTH;
                    default:             nbr_next = tgff_pkg::NBR_EAST;
                endcase
            end
            tgff_pkg::ST_DONE:
            begin
                depth_next = '0;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_old_next   = old_reg;
                    out_chg_next   = chg_reg;
                end
            end
            default:
            begin
                depth_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tgff_pkg::ST_CLEAR;
            clr_reg       <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            nbr_reg       <= tgff_pkg::NBR_EAST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            nbr_reg       <= nbr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        tile_reg    <= tile_next;
        old_reg     <= old_next;
        chg_reg     <= chg_next;
        out_old_reg <= out_old_next;
        out_chg_reg <= out_chg_next;
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_waddr] <= grid_wdata;
        if (grid_re)
            grid_rd_reg <= grid_mem[grid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rd_reg <= stk_mem[stk_raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_chg_reg, out_old_reg};

endmodule

// ===== test/tgff_flood_checker.sv =====
// Scoreboard for tile_grid_flood_fill: watches both stream channels, keeps its own
// copy of the tile grid and fill stack, and compares every reply word in order.
// Depends on tgff_pkg for field widths and mode codes.
module tgff_flood_checker #(
    parameter int GRID_WIDTH  = 20,
    parameter int GRID_HEIGHT = 18,
    parameter int STACK_SIZE  = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [1:0] mode, [6:2] col, [11:7] row, [19:12] wr_tile, [23:20] zero
    input  logic [tgff_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] prev_tile, [8] changed, [15:9] zero
    input  logic [tgff_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending,
    output int                              fills_changed,
    output int                              peak_depth,
    output int                              push_skips
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_PAD_W = tgff_pkg::S_TDATA_W - tgff_pkg::MODE_W
                               - 2*tgff_pkg::POS_W - tgff_pkg::TILE_W;
    localparam int REP_PAD_W = tgff_pkg::M_TDATA_W - tgff_pkg::TILE_W - 1;

    typedef struct packed {
        logic [CMD_PAD_W-1:0]            pad;
        logic [tgff_pkg::TILE_W-1:0]     wr_tile;
        logic [tgff_pkg::POS_W-1:0]      row;
        logic [tgff_pkg::POS_W-1:0]      col;
        logic [tgff_pkg::MODE_W-1:0]     mode;
    } grid_cmd_t;

    typedef struct packed {
        logic [REP_PAD_W-1:0]            pad;
        logic                            changed;
        logic [tgff_pkg::TILE_W-1:0]     prev_tile;
    } tile_reply_t;

    logic [tgff_pkg::TILE_W-1:0]      grid_model [GRID_WIDTH*GRID_HEIGHT];
    logic [2*tgff_pkg::COORD_W-1:0]   coord_stack [STACK_SIZE];
    int                               stack_fill;
    tile_reply_t                      expected_replies [$];

    function automatic void push_coord(logic [tgff_pkg::COORD_W-1:0] c,
                                       logic [tgff_pkg::COORD_W-1:0] r);
        if (stack_fill < STACK_SIZE)
        begin
            coord_stack[stack_fill] = {r, c};
            stack_fill++;
            if (stack_fill > peak_depth)
                peak_depth = stack_fill;
        end
    endfunction

    // Depth-first region replace. Coordinates are 6-bit, so col-1 at col 0
    // wraps to 63 and is dropped on pop like any other off-grid entry.
    function automatic void flood_region(logic [tgff_pkg::COORD_W-1:0] c0,
                                         logic [tgff_pkg::COORD_W-1:0] r0,
                                         logic [tgff_pkg::TILE_W-1:0]  old_t,
                                         logic [tgff_pkg::TILE_W-1:0]  new_t);
        logic [tgff_pkg::COORD_W-1:0] c;
        logic [tgff_pkg::COORD_W-1:0] r;
        int                           idx;
        stack_fill = 0;
        push_coord(c0, r0);
        while (stack_fill > 0)
        begin
            stack_fill--;
            {r, c} = coord_stack[stack_fill];
            if (c >= GRID_WIDTH || r >= GRID_HEIGHT)
                continue;
            idx = int'(r) * GRID_WIDTH + int'(c);
            if (grid_model[idx] != old_t)
                continue;
            grid_model[idx] = new_t;
            // neighbours go in only while four more still fit
            if (stack_fill + 4 < STACK_SIZE)
            begin
                push_coord(c + 6'd1, r);
                push_coord(c - 6'd1, r);
                push_coord(c, r + 6'd1);
                push_coord(c, r - 6'd1);
            end
            else
                push_skips++;
        end
        stack_fill = 0;
    endfunction

    function automatic tile_reply_t apply_command(grid_cmd_t cmd);
        tile_reply_t rep;
        int          idx;
        rep = '0;
        if (cmd.col < GRID_WIDTH && cmd.row < GRID_HEIGHT)
        begin
            idx = int'(cmd.row) * GRID_WIDTH + int'(cmd.col);
            rep.prev_tile = grid_model[idx];
            if (cmd.mode == tgff_pkg::MODE_PAINT)
            begin
                grid_model[idx] = cmd.wr_tile;
                rep.changed = 1'b1;
            end
            else if (cmd.mode == tgff_pkg::MODE_FILL && rep.prev_tile != cmd.wr_tile)
            begin
                flood_region({1'b0, cmd.col}, {1'b0, cmd.row}, rep.prev_tile, cmd.wr_tile);
                rep.changed = 1'b1;
                fills_changed++;
            end
        end
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tile_reply_t got;
        tile_reply_t want;
        if (!rst_n)
        begin
            foreach (grid_model[i])
                grid_model[i] = '0;
            expected_replies.delete();
            stack_fill    = 0;
            fail_count    = 0;
            pending       = 0;
            fills_changed = 0;
            peak_depth    = 0;
            push_skips    = 0;
        end
        else
        begin
            // reply first: a word accepted this edge can't belong to a command taken now
            if (m_tvalid && m_tready)
            begin
                got = tile_reply_t'(m_tdata);
                if (expected_replies.size() == 0)
                begin
                    $error("reply word 0x%0h with no command outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.prev_tile !== want.prev_tile)
                    begin
                        $error("prev_tile mismatch: expected %0d, got %0d",
                               want.prev_tile, got.prev_tile);
                        fail_count++;
                    end
                    if (got.changed !== want.changed)
                    begin
                        $error("changed mismatch: expected %0d, got %0d",
                               want.changed, got.changed);
                        fail_count++;
                    end
                    if (got.pad !== want.pad)
                    begin
                        $error("padding mismatch: expected %0d, got %0d", want.pad, got.pad);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_replies.push_back(apply_command(grid_cmd_t'(s_tdata)));
            pending = expected_replies.size();
        end
    end

endmodule

// ===== test/tb_tile_grid_flood_fill.sv =====
// Top of the tile_grid_flood_fill testbench: clock, reset, command stimulus,
// reply back-pressure, watchdog and verdict. Depends on tgff_pkg,
// tile_grid_flood_fill and tgff_flood_checker.
module tb_tile_grid_flood_fill;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_WIDTH  = 20;
    localparam int GRID_HEIGHT = 18;
    localparam int STACK_SIZE  = 1024;

    // mode code the block has no use for; it must behave as a read
    localparam logic [tgff_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 400;
    // The limit covers the worst fill, with no handshake at all, plus the longest
    // reply stall, and the clear sweep after reset, several times over.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 40;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // [1:0] mode, [6:2] col, [11:7] row, [19:12] wr_tile, [23:20] zero
    logic [tgff_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // [7:0] prev_tile, [8] changed, [15:9] zero
    logic [tgff_pkg::M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int fills_changed;
    int peak_depth;
    int push_skips;

    int quiet_cycles = 0;
    int burst_left   = 0;
    int gap_max      = 0;
    int stall_style  = 0;
    int stall_timer  = 0;
    int mode_count [4] = '{0, 0, 0, 0};
    int offgrid_count = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    tile_grid_flood_fill #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .STACK_SIZE  (STACK_SIZE)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    tgff_flood_checker #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .STACK_SIZE  (STACK_SIZE)
    ) flood_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .fills_changed (fills_changed),
        .peak_depth    (peak_depth),
        .push_skips    (push_skips)
    );

    // Reply back-pressure. A new style is drawn whenever stall_timer runs out:
    // always ready, coin toss, mostly stalled, or long stall stretches. The style
    // change lands on random points of fills and reads alike.
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_timer <= 97;
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_timer % 24) < 4;
        endcase
    end

    // Watchdog: any accepted word on either side resets the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no word accepted for %0d cycles, %0d replies outstanding",
                 WATCHDOG_LIMIT, pending);
        $display("== FAIL ==");
        $finish;
    end

    // One command word. Bursts of 1..6 words, then an idle gap no longer than
    // gap_max; gap_max of zero keeps tvalid high back to back.
    task automatic send_cmd(input logic [tgff_pkg::MODE_W-1:0] mode, input int col,
                            input int row, input int tile);
        if (gap_max > 0 && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clk);
            burst_left = $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tgff_pkg::S_TDATA_W'({tile[tgff_pkg::TILE_W-1:0],
                                          row[tgff_pkg::POS_W-1:0],
                                          col[tgff_pkg::POS_W-1:0], mode});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        mode_count[mode]++;
        if (col >= GRID_WIDTH || row >= GRID_HEIGHT)
            offgrid_count++;
    endtask

    // Mostly on-grid cells and a four-tile palette so regions form and
    // fills actually walk; the rest hits the whole field range.
    task automatic send_random_cmd();
        int                          pick;
        logic [tgff_pkg::MODE_W-1:0] mode;
        int                          col;
        int                          row;
        int                          tile;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            mode = tgff_pkg::MODE_READ;
        else if (pick < 78)
            mode = tgff_pkg::MODE_PAINT;
        else if (pick < 94)
            mode = tgff_pkg::MODE_FILL;
        else
            mode = MODE_UNUSED;
        col  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(0, GRID_WIDTH - 1);
        row  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(0, GRID_HEIGHT - 1);
        tile = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        send_cmd(mode, col, row, tile);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: corners, off-grid in each coordinate, all-ones fields,
        // the unused mode, whole-grid fills that push the stack hardest,
        // a fill with the same tile and single-cell fills.
        gap_max = 2;
        send_cmd(tgff_pkg::MODE_READ,  0,  0,  0);
        send_cmd(tgff_pkg::MODE_READ,  19, 17, 0);
        send_cmd(tgff_pkg::MODE_FILL,  0,  0,  8'hAA);   // uniform grid, every cell
        send_cmd(tgff_pkg::MODE_READ,  20, 0,  0);
        send_cmd(tgff_pkg::MODE_READ,  0,  18, 0);
        send_cmd(tgff_pkg::MODE_READ,  31, 31, 8'hFF);
        send_cmd(MODE_UNUSED,          5,  5,  8'hFF);
        send_cmd(tgff_pkg::MODE_PAINT, 0,  0,  8'hFF);
        send_cmd(tgff_pkg::MODE_PAINT, 19, 17, 8'hFF);
        send_cmd(tgff_pkg::MODE_PAINT, 31, 31, 8'h07);
        send_cmd(tgff_pkg::MODE_FILL,  10, 9,  8'hAA);   // same tile, no change
        send_cmd(tgff_pkg::MODE_FILL,  10, 9,  8'h55);   // all but two corners
        send_cmd(tgff_pkg::MODE_FILL,  0,  0,  8'h00);   // lone corner
        send_cmd(tgff_pkg::MODE_FILL,  20, 5,  8'h11);
        send_cmd(tgff_pkg::MODE_FILL,  3,  31, 8'h11);
        send_cmd(tgff_pkg::MODE_PAINT, 19, 0,  8'h00);
        send_cmd(tgff_pkg::MODE_READ,  19, 0,  0);
        send_cmd(tgff_pkg::MODE_PAINT, 10, 10, 8'h80);
        send_cmd(tgff_pkg::MODE_FILL,  19, 17, 8'h00);
        send_cmd(tgff_pkg::MODE_FILL,  5,  5,  8'h00);   // big region back to zero
        send_cmd(tgff_pkg::MODE_READ,  10, 10, 0);
        send_cmd(tgff_pkg::MODE_FILL,  0,  17, 8'h01);
        send_cmd(tgff_pkg::MODE_READ,  1,  1,  0);

        // Random part in four quarters with different sender idling.
        for (int q = 0; q < 4; q++)
        begin
            case (q)
                0: gap_max = 0;
                1: gap_max = 3;
                2: gap_max = 12;
                default: gap_max = 1;
            endcase
            burst_left = 0;
            for (int n = 0; n < RANDOM_WORDS / 4; n++)
                send_random_cmd();
        end
        s_tvalid <= 1'b0;

        // one edge so the checker has queued the last command
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d reads, %0d paints, %0d fills, %0d unused-mode, %0d off grid",
                 mode_count[tgff_pkg::MODE_READ], mode_count[tgff_pkg::MODE_PAINT],
                 mode_count[tgff_pkg::MODE_FILL], mode_count[MODE_UNUSED], offgrid_count);
        $display("%0d fills changed the grid; peak stack depth %0d, %0d pushes held back",
                 fills_changed, peak_depth, push_skips);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
